@@ hdl/lphf_pkg.sv @@
// ---------------------------------------------------------------------------
// lphf_pkg - shared definitions of the ladder low-pass / high-pass filter
// Fixed-point formats, constants, the sequencer states and the status
// group that the serial arithmetic units report to the sequencer.
// ---------------------------------------------------------------------------
package lphf_pkg;

  // default sample width, Q3.(SAMPLE_BITS-4)
  localparam int SAMPLE_BITS_DEF = 24;

  // state format Q5.26
  localparam int STATE_W    = 32;
  localparam int STATE_FRAC = 26;
  // the sample is shifted by this minus its width to land on the state binary point
  localparam int SAMPLE_ALIGN = STATE_FRAC + 4;

  // control fields, Q0.16
  localparam int CTRL_W    = 16;
  localparam int CTRL_FRAC = 16;

  // cutoff and sample rate
  localparam int CUT_W  = 17;
  localparam int RATE_W = 18;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  // coefficient, unsigned Q2.28, saturating at 2^30-1
  localparam int COEF_W    = 30;
  localparam int COEF_FRAC = 28;
  // 2*pi*0.67 in Q32
  localparam logic [35:0] K_Q32 = 36'd18080670524;
  // quotient bits dropped below the coefficient
  localparam int DIV_SH = 32 - COEF_FRAC;

  // feedback clamp, 3.0 in Q5.26
  localparam logic signed [STATE_W-1:0] FB_LIMIT = 32'sd201326592;

  // drive gain 1 + 3*drive, 18 bits unsigned
  localparam int GAIN_W = CTRL_W + 2;

  // shared serial multiplier: signed multiplicand, unsigned multiplier
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 30;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_RATE = 1'b0;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KMUL,
    ST_RES,
    ST_GAIN,
    ST_MIX,
    ST_DIVW,
    ST_STAGE,
    ST_OUT
  } lphf_state_t;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } lphf_stat_t;

endpackage

@@ hdl/lphf_sermul.sv @@
// ---------------------------------------------------------------------------
// lphf_sermul - radix-4 digit-serial multiplier
// Signed multiplicand times unsigned multiplier, two multiplier bits per
// cycle, least significant digit first. The accumulator shifts right so the
// adder stays only a little wider than the multiplicand.
// ---------------------------------------------------------------------------
module lphf_sermul
  import lphf_pkg::*;
#(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [AW-1:0]           a_in,
  input  logic        [BW-1:0]           b_in,
  output logic signed [AW+2*((BW+1)/2)-1:0] prod,
  output lphf_stat_t                     stat
);

  localparam int NSTEP = (BW + 1) / 2;
  localparam int LW    = 2 * NSTEP;
  localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam logic [CW-1:0] LAST = CW'(NSTEP - 1);

  logic signed [AW-1:0]   a_r;
  logic        [LW-1:0]   b_r;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic        [LW-1:0]   lo_r, lo_nxt;
  logic        [CW-1:0]   cnt_r;
  logic                   busy_r, done_r;
  logic signed [AW+1:0]   pp, sum;

  // partial product of one digit
  always_comb begin
    pp = '0;
    if (b_r[0]) pp = pp + {{2{a_r[AW-1]}}, a_r};
    if (b_r[1]) pp = pp + {a_r[AW-1], a_r, 1'b0};
    sum     = {{2{acc_r[AW-1]}}, acc_r} + pp;
    acc_nxt = sum[AW+1:2];
    lo_nxt  = {sum[1:0], lo_r[LW-1:2]};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_in;
      b_r   <= LW'(b_in);
      acc_r <= '0;
      lo_r  <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      lo_r  <= lo_nxt;
      b_r   <= b_r >> 2;
    end
  end

  assign prod = $signed({acc_r, lo_r});
  assign stat = '{busy: busy_r, done: done_r};

endmodule

@@ hdl/lphf_serdiv.sv @@
// ---------------------------------------------------------------------------
// lphf_serdiv - bit-serial restoring divider for the cutoff coefficient
// Divides a dividend given as a high part and a low part by an unsigned
// divisor, one quotient bit per cycle. When the high part already reaches
// the divisor the quotient would overflow and the result saturates at once.
// ---------------------------------------------------------------------------
module lphf_serdiv
  import lphf_pkg::*;
#(
  parameter int QW = COEF_W,
  parameter int DW = RATE_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num_hi,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output lphf_stat_t    stat
);

  localparam int CW = (QW > 1) ? $clog2(QW) : 1;
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] sh_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  // one restoring step
  always_comb begin
    trial   = {rem_r, sh_r[QW-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (num_hi >= den) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend / quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= num_hi;
      sh_r  <= (num_hi >= den) ? {QW{1'b1}} : num_lo;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[QW-2:0], ge};
    end
  end

  assign quo  = sh_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule

@@ hdl/ladder_lowpass_highpass_filter_unit.sv @@
// ---------------------------------------------------------------------------
// ladder_lowpass_highpass_filter_unit - four-pole ladder filter, one channel
// Takes one sample with its cutoff, resonance, drive and blend per item and
// returns one filtered, saturated sample.
// ---------------------------------------------------------------------------
// One item at a time: an accepted sample yields its result and the next
// item is taken in the cycle after that result is loaded into the output
// register. The sequence runs on the shared radix-4 serial multiplier,
// which runs eight products one after another (cutoff scaling, feedback,
// drive, blend and the four one-pole stages); the coefficient division
// runs beside the feedback and drive products. The sample rate register at
// byte address 0 is written while no item is in flight: the user must keep
// to this, the block itself does not enforce it. It reads back on cfg_prdata.
// ---------------------------------------------------------------------------
module ladder_lowpass_highpass_filter_unit
  import lphf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input items
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // sample_in, cutoff_hz, resonance, drive_amount, highpass_mix, zero pad
  input  logic [((SAMPLE_BITS+CUT_W+3*CTRL_W+7)/8)*8-1:0] in_tdata,
  // result items
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // sample_out, zero pad
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  // configuration
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [CFG_AW-1:0]         cfg_paddr,
  input  logic [CFG_DW-1:0]         cfg_pwdata,
  output logic [CFG_DW-1:0]         cfg_prdata,
  output logic                      cfg_pready
);

  localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CUT_LO = SAMPLE_BITS;
  localparam int RES_LO = CUT_LO + CUT_W;
  localparam int DRV_LO = RES_LO + CTRL_W;
  localparam int MIX_LO = DRV_LO + CTRL_W;
  localparam int XW     = STATE_W + 2;
  localparam int YW     = STATE_W + 4;
  localparam int UP_SH  = (SAMPLE_BITS <= SAMPLE_ALIGN) ? SAMPLE_ALIGN - SAMPLE_BITS : 0;
  localparam int DN_SH  = (SAMPLE_BITS > SAMPLE_ALIGN) ? SAMPLE_BITS - SAMPLE_ALIGN : 0;

  localparam logic signed [MUL_PW-1:0] ST_HI =
    {{(MUL_PW-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
  localparam logic signed [MUL_PW-1:0] ST_LO = ~ST_HI;
  localparam logic signed [YW-1:0] OUT_HI =
    {{(YW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [YW-1:0] OUT_LO = ~OUT_HI;

  // saturate a wide product result to the state range
  function automatic logic signed [STATE_W-1:0] sat_st(input logic signed [MUL_PW-1:0] v);
    logic signed [MUL_PW-1:0] t;
    t = v;
    if (t > ST_HI) t = ST_HI;
    else if (t < ST_LO) t = ST_LO;
    return t[STATE_W-1:0];
  endfunction

  lphf_state_t state_r, state_nxt;

  logic [RATE_W-1:0]             rate_r;
  logic [SAMPLE_BITS-1:0]        x_r;
  logic [CUT_W-1:0]              cut_r;
  logic [CTRL_W-1:0]             res_r, drv_amt_r, mix_r;
  logic signed [STATE_W-1:0]     stage_r [4];
  logic signed [STATE_W-1:0]     fbt_r, prev_r, mixt_r;
  logic [1:0]                    idx_r;
  logic                          mul_run_r;
  logic [SAMPLE_BITS-1:0]        out_data_r;
  logic                          out_valid_r;

  logic                          in_fire, cfg_wr;
  logic                          mul_start, mul_state, div_start;
  logic signed [MUL_AW-1:0]      mul_a;
  logic [MUL_BW-1:0]             mul_b;
  logic signed [MUL_PW-1:0]      mul_prod, prod_sh16, prod_sh28, st_sum;
  lphf_stat_t                    mul_st, div_st;
  logic [COEF_W-1:0]             coef;
  logic signed [XW-1:0]          xw, xs_w;
  logic signed [STATE_W-1:0]     xs, fb, st_new, drv_new;
  logic [STATE_W:0]              d_gain, d_stage, y33;
  logic [GAIN_W-1:0]             gain;
  logic signed [YW-1:0]          y_w, y_al, y_sat;
  logic                          out_load;

  assign in_fire = in_tvalid && in_tready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // sample into the state format
  always_comb begin
    xw   = $signed({{(XW-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r});
    xs_w = (xw <<< UP_SH) >>> DN_SH;
    xs   = xs_w[STATE_W-1:0];
  end

  // clamped feedback and drive gain
  always_comb begin
    if (stage_r[3] > FB_LIMIT) fb = FB_LIMIT;
    else if (stage_r[3] < -FB_LIMIT) fb = -FB_LIMIT;
    else fb = stage_r[3];
    gain    = (GAIN_W'(1) << CTRL_FRAC) + GAIN_W'(drv_amt_r) * GAIN_W'(3);
    d_gain  = {xs[STATE_W-1], xs} - {fbt_r[STATE_W-1], fbt_r};
    d_stage = {prev_r[STATE_W-1], prev_r} - {stage_r[0][STATE_W-1], stage_r[0]};
  end

  // multiplier operand selection
  always_comb begin
    mul_state = 1'b1;
    unique case (state_r)
      ST_KMUL: begin
        mul_a = $signed(K_Q32);
        mul_b = MUL_BW'(cut_r);
      end
      ST_RES: begin
        mul_a = $signed({{(MUL_AW-STATE_W){fb[STATE_W-1]}}, fb});
        mul_b = MUL_BW'(res_r);
      end
      ST_GAIN: begin
        mul_a = $signed({{(MUL_AW-STATE_W-1){d_gain[STATE_W]}}, d_gain});
        mul_b = MUL_BW'(gain);
      end
      ST_MIX: begin
        mul_a = $signed({{(MUL_AW-STATE_W){xs[STATE_W-1]}}, xs});
        mul_b = MUL_BW'(mix_r);
      end
      ST_STAGE: begin
        mul_a = $signed({{(MUL_AW-STATE_W-1){d_stage[STATE_W]}}, d_stage});
        mul_b = MUL_BW'(coef);
      end
      default: begin
        mul_state = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
      end
    endcase
  end

  assign mul_start = mul_state && !mul_run_r;
  assign div_start = (state_r == ST_KMUL) && mul_st.done;

  lphf_sermul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .prod  (mul_prod),
    .stat  (mul_st)
  );

  lphf_serdiv #(
    .QW (COEF_W),
    .DW (RATE_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (mul_prod[DIV_SH+COEF_W+RATE_W-1:DIV_SH+COEF_W]),
    .num_lo (mul_prod[DIV_SH+COEF_W-1:DIV_SH]),
    .den    (rate_r),
    .quo    (coef),
    .stat   (div_st)
  );

  // product scaling and stage update
  always_comb begin
    prod_sh16 = mul_prod >>> CTRL_FRAC;
    prod_sh28 = mul_prod >>> COEF_FRAC;
    st_sum    = $signed({{(MUL_PW-STATE_W){stage_r[0][STATE_W-1]}}, stage_r[0]}) + prod_sh28;
    st_new    = sat_st(st_sum);
    drv_new   = sat_st(prod_sh16);
  end

  // output blend, alignment and saturation
  always_comb begin
    y33   = {prev_r[STATE_W-1], prev_r} - {mixt_r[STATE_W-1], mixt_r};
    y_w   = $signed({{(YW-STATE_W-1){y33[STATE_W]}}, y33});
    y_al  = (y_w <<< DN_SH) >>> UP_SH;
    if (y_al > OUT_HI) y_sat = OUT_HI;
    else if (y_al < OUT_LO) y_sat = OUT_LO;
    else y_sat = y_al;
    out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_KMUL;
      ST_KMUL:  if (mul_st.done) state_nxt = ST_RES;
      ST_RES:   if (mul_st.done) state_nxt = ST_GAIN;
      ST_GAIN:  if (mul_st.done) state_nxt = ST_MIX;
      ST_MIX:   if (mul_st.done) state_nxt = ST_DIVW;
      ST_DIVW:  if (!div_st.busy) state_nxt = ST_STAGE;
      ST_STAGE: if (mul_st.done && idx_r == 2'd3) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= RATE_RESET;
      mul_run_r   <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) stage_r[i] <= '0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_RATE) rate_r <= cfg_pwdata[RATE_W-1:0];
      if (mul_start) mul_run_r <= 1'b1;
      else if (mul_st.done) mul_run_r <= 1'b0;
      if (state_r == ST_DIVW) idx_r <= 2'd0;
      // stages rotate through position 0, back in order after four steps
      if (state_r == ST_STAGE && mul_st.done) begin
        idx_r      <= idx_r + 2'd1;
        stage_r[0] <= stage_r[1];
        stage_r[1] <= stage_r[2];
        stage_r[2] <= stage_r[3];
        stage_r[3] <= st_new;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // item capture and intermediate results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r       <= in_tdata[SAMPLE_BITS-1:0];
      cut_r     <= in_tdata[RES_LO-1:CUT_LO];
      res_r     <= in_tdata[DRV_LO-1:RES_LO];
      drv_amt_r <= in_tdata[MIX_LO-1:DRV_LO];
      mix_r     <= in_tdata[MIX_LO+CTRL_W-1:MIX_LO];
    end
    if (mul_st.done) begin
      unique case (state_r)
        ST_RES:   fbt_r  <= prod_sh16[STATE_W-1:0];
        ST_GAIN:  prev_r <= drv_new;
        ST_MIX:   mixt_r <= prod_sh16[STATE_W-1:0];
        ST_STAGE: prev_r <= st_new;
        default: ;
      endcase
    end
    if (out_load) out_data_r <= y_sat[SAMPLE_BITS-1:0];
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_RATE) ? CFG_DW'(rate_r) : '0;

  // an accepted item always starts with the cutoff product
  a_fire_kmul: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_KMUL))
    else $error("item accepted without starting the cutoff product");

  // the stages never start before the coefficient is ready
  a_coef_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STAGE) |-> !div_st.busy)
    else $error("stage update running while the divider is busy");

  // the divider only finishes within the item sequence
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_RES || state_r == ST_GAIN || state_r == ST_MIX ||
                     state_r == ST_DIVW))
    else $error("divider finished outside the item sequence");

  // a result appears only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result raised outside the output state");

endmodule
